// File: sv/tpkm_pkg.sv
// shared types and constants for the trend pattern kmp matcher
`default_nettype none

package tpkm_pkg;

    // item opcodes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // trend symbols
    localparam logic [1:0] SYM_G     = 2'd0;
    localparam logic [1:0] SYM_L     = 2'd1;
    localparam logic [1:0] SYM_E     = 2'd2;
    localparam logic [1:0] SYM_OTHER = 2'd3;

    // width of the reported prefix length
    localparam int PLEN_W = 7;

    // depth of the command queue between front and back
    localparam int Q_DEPTH = 2;

    // classified command handed from front to back
    typedef struct packed {
        logic [1:0] op;
        logic [1:0] sym;
        logic       step;
    } tpkm_cmd_t;

endpackage

`default_nettype wire

// File: sv/tpkm_ram.sv
// generic single write port ram with registered read
`default_nettype none

module tpkm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: sv/tpkm_front.sv
// front end: accepts items, forms trend symbols, pushes commands
`default_nettype none

module tpkm_front
    import tpkm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         opcode,
    input  wire logic [1:0]         pattern_symbol,
    input  wire logic signed [31:0] sample_value,
    input  wire logic               q_full,
    output logic                    q_push,
    output tpkm_cmd_t               q_data
);

    logic signed [31:0] prev_sample_reg;
    logic               have_prev_reg;
    logic [1:0]         trend_sym;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // compare with the previous sample
    always_comb
    begin
        if (sample_value > prev_sample_reg)
        begin
            trend_sym = SYM_G;
        end
        else if (sample_value < prev_sample_reg)
        begin
            trend_sym = SYM_L;
        end
        else
        begin
            trend_sym = SYM_E;
        end
    end

    // classify the item
    always_comb
    begin
        q_data.op   = opcode;
        q_data.sym  = (opcode == OP_SAMPLE) ? trend_sym : pattern_symbol;
        q_data.step = have_prev_reg;
    end

    // previous sample tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
        end
        else if (q_push)
        begin
            if (opcode == OP_CLEAR)
            begin
                have_prev_reg <= 1'b0;
            end
            else if (opcode == OP_SAMPLE)
            begin
                have_prev_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push && opcode == OP_SAMPLE)
        begin
            prev_sample_reg <= sample_value;
        end
    end

endmodule

`default_nettype wire

// File: sv/tpkm_queue.sv
// short command queue between front and back
`default_nettype none

module tpkm_queue
    import tpkm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire tpkm_cmd_t push_data,
    output logic           full,
    input  wire logic      pop,
    output logic           head_valid,
    output tpkm_cmd_t      head_data
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNW = $clog2(Q_DEPTH + 1);

    tpkm_cmd_t        entry_reg [Q_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CNW-1:0]   count_reg;

    assign full       = (count_reg == CNW'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNW'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/tpkm_back.sv
// back end: pattern build and kmp matcher stepping through the tables
`default_nettype none

module tpkm_back
    import tpkm_pkg::*;
#(
    parameter int MAX_PATTERN = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  wire tpkm_cmd_t         head_data,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   found,
    output logic                   matched_here,
    output logic                   pattern_overflow,
    output logic [PLEN_W-1:0]      partial_length
);

    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CW = $clog2(MAX_PATTERN + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic          state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] border_reg, border_next;
    logic [CW-1:0] match_reg, match_next;
    logic [CW-1:0] walk_reg, walk_next;
    logic          found_reg, found_next;
    logic          ovf_reg, ovf_next;
    logic          mode_app_reg, mode_app_next;
    logic [1:0]    sym_reg, sym_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_found_reg, out_found_next;
    logic          out_here_reg, out_here_next;
    logic          out_ovf_reg, out_ovf_next;
    logic [CW-1:0] out_len_reg, out_len_next;

    logic          out_free;
    logic          emit;
    logic          here;
    logic [CW-1:0] rd_l;
    logic [CW-1:0] l_new;
    logic          fall;

    logic          ps_we;
    logic [AW-1:0] ps_waddr;
    logic [1:0]    ps_wdata;
    logic [1:0]    ps_rdata;
    logic          ft_we;
    logic [AW-1:0] ft_waddr;
    logic [CW-1:0] ft_wdata;
    logic [CW-1:0] ft_rdata;

    assign out_free = !out_valid_reg || !out_stall;
    assign fall     = (walk_reg != '0) && (ps_rdata != sym_reg);
    assign l_new    = walk_reg + CW'(ps_rdata == sym_reg);

    // pattern symbol store
    tpkm_ram #(
        .WIDTH (2),
        .DEPTH (MAX_PATTERN)
    ) u_pattern_ram (
        .clk     (clk),
        .wr_en   (ps_we),
        .wr_addr (ps_waddr),
        .wr_data (ps_wdata),
        .rd_addr (rd_l[AW-1:0]),
        .rd_data (ps_rdata)
    );

    // failure table
    tpkm_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_PATTERN)
    ) u_failure_ram (
        .clk     (clk),
        .wr_en   (ft_we),
        .wr_addr (ft_waddr),
        .wr_data (ft_wdata),
        .rd_addr (AW'(rd_l - CW'(1))),
        .rd_data (ft_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        border_next   = border_reg;
        match_next    = match_reg;
        walk_next     = walk_reg;
        found_next    = found_reg;
        ovf_next      = ovf_reg;
        mode_app_next = mode_app_reg;
        sym_next      = sym_reg;
        pop           = 1'b0;
        emit          = 1'b0;
        here          = 1'b0;
        rd_l          = walk_reg;
        ps_we         = 1'b0;
        ps_waddr      = count_reg[AW-1:0];
        ps_wdata      = head_data.sym;
        ft_we         = 1'b0;
        ft_waddr      = count_reg[AW-1:0];
        ft_wdata      = l_new;

        case (state_reg)
            ST_IDLE:
            begin
                rd_l = (head_data.op == OP_APPEND) ? border_reg : match_reg;
                if (head_valid && out_free)
                begin
                    pop = 1'b1;
                    case (head_data.op)
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            border_next = '0;
                            match_next  = '0;
                            found_next  = 1'b0;
                            ovf_next    = 1'b0;
                            emit        = 1'b1;
                        end
                        OP_APPEND:
                        begin
                            if (count_reg == CW'(MAX_PATTERN))
                            begin
                                ovf_next = 1'b1;
                                emit     = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                ps_we       = 1'b1;
                                ft_we       = 1'b1;
                                ft_wdata    = '0;
                                border_next = '0;
                                count_next  = CW'(1);
                                emit        = 1'b1;
                            end
                            else
                            begin
                                ps_we         = 1'b1;
                                walk_next     = border_reg;
                                mode_app_next = 1'b1;
                                sym_next      = head_data.sym;
                                state_next    = ST_WALK;
                            end
                        end
                        OP_SAMPLE:
                        begin
                            if (!head_data.step || found_reg || count_reg == '0)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                walk_next     = match_reg;
                                mode_app_next = 1'b0;
                                sym_next      = head_data.sym;
                                state_next    = ST_WALK;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (fall)
                begin
                    // fall back through the failure table
                    walk_next = ft_rdata;
                    rd_l      = ft_rdata;
                end
                else
                begin
                    state_next = ST_IDLE;
                    emit       = 1'b1;
                    if (mode_app_reg)
                    begin
                        ft_we       = 1'b1;
                        border_next = l_new;
                        count_next  = count_reg + CW'(1);
                    end
                    else if (l_new >= count_reg)
                    begin
                        match_next = count_reg;
                        found_next = 1'b1;
                        here       = 1'b1;
                    end
                    else
                    begin
                        match_next = l_new;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_found_next = out_found_reg;
        out_here_next  = out_here_reg;
        out_ovf_next   = out_ovf_reg;
        out_len_next   = out_len_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_found_next = found_next;
            out_here_next  = here;
            out_ovf_next   = ovf_next;
            out_len_next   = match_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            border_reg    <= '0;
            match_reg     <= '0;
            found_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            border_reg    <= border_next;
            match_reg     <= match_next;
            found_reg     <= found_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // walk and result payload
    always_ff @(posedge clk)
    begin
        walk_reg      <= walk_next;
        mode_app_reg  <= mode_app_next;
        sym_reg       <= sym_next;
        out_found_reg <= out_found_next;
        out_here_reg  <= out_here_next;
        out_ovf_reg   <= out_ovf_next;
        out_len_reg   <= out_len_next;
    end

    assign out_valid        = out_valid_reg;
    assign found            = out_found_reg;
    assign matched_here     = out_here_reg;
    assign pattern_overflow = out_ovf_reg;
    assign partial_length   = PLEN_W'(out_len_reg);

endmodule

`default_nettype wire

// File: sv/trend_pattern_kmp_matcher_core.sv
// top level of the trend pattern kmp matcher
//
// channel  direction  handshake            payload
// input    in         in_valid / in_stall  opcode, pattern_symbol, sample_value
// result   out        out_valid / out_stall found, matched_here, pattern_overflow,
//                                          partial_length
//
// an accepted transaction enters the command queue in the cycle it is taken.
// clear, no-op, the first pattern symbol, an append to a full pattern, a first
// sample, a sample after a match and a sample with an empty pattern finish in the
// back-end idle state; any other append or sample goes on to the walk state, which
// steps through failure-table fallbacks via the registered read ports of the tables.
// reset is asynchronous; the tables hold no reset value and need no clearing.
// a stalled result holds in the output register; the queue takes input until full.
`default_nettype none

module trend_pattern_kmp_matcher_core
    import tpkm_pkg::*;
#(
    parameter int MAX_PATTERN = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         opcode,
    input  wire logic [1:0]         pattern_symbol,
    input  wire logic signed [31:0] sample_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    found,
    output logic                    matched_here,
    output logic                    pattern_overflow,
    output logic [PLEN_W-1:0]       partial_length
);

    logic      q_full;
    logic      q_push;
    tpkm_cmd_t q_push_data;
    logic      q_pop;
    logic      q_head_valid;
    tpkm_cmd_t q_head_data;

    // front end
    tpkm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .pattern_symbol (pattern_symbol),
        .sample_value   (sample_value),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_push_data)
    );

    // command queue
    tpkm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_data)
    );

    // back end
    tpkm_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_valid       (q_head_valid),
        .head_data        (q_head_data),
        .pop              (q_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .found            (found),
        .matched_here     (matched_here),
        .pattern_overflow (pattern_overflow),
        .partial_length   (partial_length)
    );

endmodule

`default_nettype wire

// File: sv/tpkm_checker.sv
// port-level checker for the trend pattern kmp matcher, bound to the top level
`default_nettype none

module tpkm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        found,
    input wire logic        matched_here,
    input wire logic        pattern_overflow,
    input wire logic [6:0]  partial_length
);

    logic [3:0] pending_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // transactions taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            pending_reg <= pending_reg + 4'd1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_reg <= pending_reg - 4'd1;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(matched_here)
            && $stable(pattern_overflow) && $stable(partial_length))
        else $error("stalled result changed");

    // a match is always reported with the sticky flag
    a_match_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && matched_here |-> found)
        else $error("matched_here without found");

    // no result without an accepted transaction behind it
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 4'd0)
        else $error("result with no pending transaction");

    // queue plus one item in the back end bounds the backlog
    a_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'd3)
        else $error("too many pending transactions");

endmodule

bind trend_pattern_kmp_matcher_core tpkm_checker u_tpkm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .found            (found),
    .matched_here     (matched_here),
    .pattern_overflow (pattern_overflow),
    .partial_length   (partial_length)
);

`default_nettype wire
